// ===== rtl/pqxm_pkg.sv =====
// shared types and codes for the priority queue with extract-max
package pqxm_pkg;

   localparam int unsigned PRIO_W   = 16;
   localparam int unsigned VALUE_W  = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W    = 5;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

// ===== rtl/priority_queue_extract_max.sv =====
// priority queue of (priority, value) pairs held in arrival order in one memory
// enqueue, full or empty: after the request transfers, the result goes through the finish state to the output
// dequeue: scans every held entry, then moves each entry behind the winner up one place, limited by the
//   single memory read port (one read per scan step, one read per close-up step)
// one command in flight; the next request transfers while a result waits at the output
// synchronous reset empties the queue; memory contents stay undefined until written
module priority_queue_extract_max #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic signed [pqxm_pkg::PRIO_W-1:0] req_priority_req,
   input  logic [pqxm_pkg::VALUE_W-1:0]     req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pqxm_pkg::STATUS_W-1:0]    rsp_status,
   output logic signed [pqxm_pkg::PRIO_W-1:0] rsp_out_priority,
   output logic [pqxm_pkg::VALUE_W-1:0]     rsp_out_value,
   output logic [pqxm_pkg::OCC_W-1:0]       rsp_occupancy
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type                    state_ff;
   logic [CW-1:0]                count_ff;
   logic [AW-1:0]                idx_ff;
   logic [AW-1:0]                best_idx_ff;
   pqxm_pkg::entry_type          best_ff;
   pqxm_pkg::entry_type          rd_data_ff;

   pqxm_pkg::status_type         res_status_ff;
   logic [pqxm_pkg::PRIO_W-1:0]  res_prio_ff;
   logic [pqxm_pkg::VALUE_W-1:0] res_value_ff;
   logic [CW-1:0]                res_occ_ff;

   logic                         rsp_valid_ff;
   pqxm_pkg::status_type         rsp_status_ff;
   logic [pqxm_pkg::PRIO_W-1:0]  rsp_prio_ff;
   logic [pqxm_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [CW-1:0]                rsp_occ_ff;

   pqxm_pkg::entry_type          mem [DEPTH];

   logic                         take;
   logic                         full;
   logic [CW-1:0]                last_idx;
   logic                         scan_better;
   logic [AW-1:0]                best_idx_in;
   pqxm_pkg::entry_type          best_in;
   logic                         scan_last;
   logic                         shift_last;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   pqxm_pkg::entry_type          wr_data;
   logic [CW+pqxm_pkg::OCC_W-1:0] occ_ext;

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;
   assign full      = (count_ff >= CW'(DEPTH));
   assign last_idx  = count_ff - CW'(1);

   // strict greater-than keeps the earliest of equal priorities
   assign scan_better = (idx_ff == '0) ||
                        ($signed(rd_data_ff.prio) > $signed(best_ff.prio));
   assign best_idx_in = scan_better ? idx_ff : best_idx_ff;
   assign best_in     = scan_better ? rd_data_ff : best_ff;
   assign scan_last   = (CW'(idx_ff) == last_idx);
   assign shift_last  = ((CW'(idx_ff) + CW'(1)) == last_idx);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take && (req_command == pqxm_pkg::CMD_ENQUEUE) && !full) begin
               wr_en         = 1'b1;
               wr_addr       = count_ff[AW-1:0];
               wr_data.prio  = req_priority_req;
               wr_data.value = req_payload;
            end else if (take && (req_command == pqxm_pkg::CMD_DEQUEUE) &&
                         (count_ff != '0)) begin
               rd_en   = 1'b1;
               rd_addr = '0;
            end
         end
         S_SCAN: begin
            if (!scan_last) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + AW'(1);
            end else if (CW'(best_idx_in) != last_idx) begin
               // first entry behind the winner, to start closing the gap
               rd_en   = 1'b1;
               rd_addr = best_idx_in + AW'(1);
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            if (!shift_last) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + AW'(2);
            end
         end
         S_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result loaded in the finish state keeps the output valid
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (take) begin
                  res_prio_ff  <= '0;
                  res_value_ff <= '0;
                  if (req_command == pqxm_pkg::CMD_ENQUEUE) begin
                     if (full) begin
                        res_status_ff <= pqxm_pkg::ST_FULL;
                        res_occ_ff    <= count_ff;
                     end else begin
                        res_status_ff <= pqxm_pkg::ST_ENQUEUED;
                        res_occ_ff    <= count_ff + CW'(1);
                        count_ff      <= count_ff + CW'(1);
                     end
                     state_ff <= S_FINISH;
                  end else if (count_ff == '0) begin
                     res_status_ff <= pqxm_pkg::ST_EMPTY;
                     res_occ_ff    <= '0;
                     state_ff      <= S_FINISH;
                  end else begin
                     idx_ff   <= '0;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               best_idx_ff <= best_idx_in;
               best_ff     <= best_in;
               if (!scan_last) begin
                  idx_ff <= idx_ff + AW'(1);
               end else begin
                  res_status_ff <= pqxm_pkg::ST_DEQUEUED;
                  res_prio_ff   <= best_in.prio;
                  res_value_ff  <= best_in.value;
                  res_occ_ff    <= last_idx;
                  if (CW'(best_idx_in) != last_idx) begin
                     idx_ff   <= best_idx_in;
                     state_ff <= S_SHIFT;
                  end else begin
                     count_ff <= last_idx;
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_SHIFT: begin
               if (shift_last) begin
                  count_ff <= last_idx;
                  state_ff <= S_FINISH;
               end else begin
                  idx_ff <= idx_ff + AW'(1);
               end
            end
            S_FINISH: begin
               // wait for the output register to free up
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_prio_ff   <= res_prio_ff;
                  rsp_value_ff  <= res_value_ff;
                  rsp_occ_ff    <= res_occ_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign occ_ext          = {{pqxm_pkg::OCC_W{1'b0}}, rsp_occ_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_occupancy    = occ_ext[pqxm_pkg::OCC_W-1:0];

endmodule

// ===== sim/priority_queue_extract_max_test.sv =====
// self-checking testbench for the stable extract-max priority queue
module priority_queue_extract_max_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH      = 16;
   localparam int unsigned PRIO_W     = pqxm_pkg::PRIO_W;
   localparam int unsigned VALUE_W    = pqxm_pkg::VALUE_W;
   localparam int unsigned STATUS_W   = pqxm_pkg::STATUS_W;
   localparam int unsigned OCC_W      = pqxm_pkg::OCC_W;
   localparam int unsigned IDLE_PCT   = 29;
   localparam int unsigned RAND_ITEMS = 1050;
   localparam int unsigned CALM_FIRST = 500;
   localparam int unsigned CALM_LAST  = 700;

   localparam logic signed [PRIO_W-1:0] FILL_PRIO [DEPTH] = '{
      16'sd0, 16'sd32767, 16'sh8000, 16'sd32767, -16'sd1, 16'sd1, 16'sd100, 16'sd100,
      -16'sd100, 16'sh5555, -16'sd21846, 16'sd7, 16'sd32767, 16'sd0, 16'sh8000, 16'sd42
   };

   typedef struct {
      pqxm_pkg::command_type       cmd;
      logic signed [PRIO_W-1:0]    prio;
      logic [VALUE_W-1:0]          value;
      bit                          drain_first;
      bit                          calm;
   } command_item_type;

   typedef struct {
      pqxm_pkg::status_type        status;
      logic signed [PRIO_W-1:0]    prio;
      logic [VALUE_W-1:0]          value;
      logic [OCC_W-1:0]            occ;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid        = 1'b0;
   logic                        req_ready;
   logic                        req_command      = pqxm_pkg::CMD_ENQUEUE;
   logic signed [PRIO_W-1:0]    req_priority_req = '0;
   logic [VALUE_W-1:0]          req_payload      = '0;
   logic                        rsp_valid;
   logic                        rsp_ready        = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic signed [PRIO_W-1:0]    rsp_out_priority;
   logic [VALUE_W-1:0]          rsp_out_value;
   logic [OCC_W-1:0]            rsp_occupancy;

   command_item_type     pending_commands[$];
   queue_result_type     expected_results[$];
   pqxm_pkg::entry_type  held_entries[$];

   int unsigned item_total     = 0;
   int unsigned accepted_total = 0;
   int unsigned mismatches     = 0;
   bit          req_fired      = 1'b0;
   bit          calm_phase     = 1'b0;

   priority_queue_extract_max #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_value    (rsp_out_value),
      .rsp_occupancy    (rsp_occupancy)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // held entries stay in arrival order; strict greater-than keeps the oldest of a tie
   function automatic queue_result_type apply_command(input command_item_type item);
      queue_result_type     res;
      pqxm_pkg::entry_type  e;
      int                   best;
      int                   i;
      res.status = pqxm_pkg::ST_ENQUEUED;
      res.prio   = '0;
      res.value  = '0;
      if (item.cmd == pqxm_pkg::CMD_ENQUEUE) begin
         if (held_entries.size() >= DEPTH) begin
            res.status = pqxm_pkg::ST_FULL;
         end else begin
            e.prio  = item.prio;
            e.value = item.value;
            held_entries.push_back(e);
         end
      end else if (held_entries.size() == 0) begin
         res.status = pqxm_pkg::ST_EMPTY;
      end else begin
         best = 0;
         for (i = 1; i < held_entries.size(); i++) begin
            if ($signed(held_entries[i].prio) > $signed(held_entries[best].prio)) begin
               best = i;
            end
         end
         res.status = pqxm_pkg::ST_DEQUEUED;
         res.prio   = held_entries[best].prio;
         res.value  = held_entries[best].value;
         held_entries.delete(best);
      end
      res.occ = OCC_W'(held_entries.size());
      return res;
   endfunction

   task automatic add_item(input pqxm_pkg::command_type cmd,
                           input logic signed [PRIO_W-1:0] prio,
                           input logic [VALUE_W-1:0] value);
      command_item_type item;
      int unsigned      idx;
      idx              = pending_commands.size();
      item.cmd         = cmd;
      item.prio        = prio;
      item.value       = value;
      item.drain_first = (idx == 23) || (idx == 300) || ($urandom_range(199) == 0);
      item.calm        = (idx >= CALM_FIRST) && (idx < CALM_LAST);
      pending_commands.push_back(item);
   endtask

   // driver: a new request goes out only once the previous one has transferred
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fired)) begin
         if (pending_commands.size() != 0 &&
             !(pending_commands[0].drain_first && expected_results.size() != 0) &&
             (pending_commands[0].calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_valid        <= 1'b1;
            req_command      <= pending_commands[0].cmd;
            req_priority_req <= pending_commands[0].prio;
            req_payload      <= pending_commands[0].value;
            calm_phase       <= pending_commands[0].calm;
            void'(pending_commands.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= calm_phase || ($urandom_range(99) >= IDLE_PCT);
   end

   // monitor: check result transfers, then predict for request transfers
   always @(posedge clock) begin
      queue_result_type want;
      command_item_type got_cmd;
      req_fired = !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with none expected, status %0d", rsp_status));
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_out_priority !== want.prio)
               report_mismatch($sformatf("priority %0d, want %0d",
                                         rsp_out_priority, want.prio));
            if (rsp_out_value !== want.value)
               report_mismatch($sformatf("value %0h, want %0h", rsp_out_value, want.value));
            if (rsp_occupancy !== want.occ)
               report_mismatch($sformatf("occupancy %0d, want %0d", rsp_occupancy, want.occ));
         end
      end
      if (req_fired) begin
         got_cmd.cmd         = pqxm_pkg::command_type'(req_command);
         got_cmd.prio        = req_priority_req;
         got_cmd.value       = req_payload;
         got_cmd.drain_first = 1'b0;
         got_cmd.calm        = 1'b0;
         expected_results.push_back(apply_command(got_cmd));
         accepted_total++;
      end
   end

   initial begin
      int                       burst;
      int                       enq_pct;
      logic signed [PRIO_W-1:0] prio;
      pqxm_pkg::command_type    cmd;

      // directed: empty, fill with extremes and ties, full, then serve the ties
      add_item(pqxm_pkg::CMD_DEQUEUE, 16'sd0, 8'h00);
      for (int i = 0; i < DEPTH; i++) begin
         add_item(pqxm_pkg::CMD_ENQUEUE, FILL_PRIO[i], VALUE_W'(i * 17));
      end
      add_item(pqxm_pkg::CMD_ENQUEUE, 16'sd32767, 8'h5A);
      repeat (5) add_item(pqxm_pkg::CMD_DEQUEUE, -16'sd1, 8'hA5);

      // random bursts biased towards filling, draining or balance
      while (pending_commands.size() < RAND_ITEMS) begin
         burst = $urandom_range(40, 4);
         case ($urandom_range(2))
            0: begin
               enq_pct = 85;
            end
            1: begin
               enq_pct = 15;
            end
            default: begin
               enq_pct = 50;
            end
         endcase
         repeat (burst) begin
            case ($urandom_range(3))
               0: begin
                  prio = PRIO_W'($urandom_range(4)) - 16'sd2;
               end
               1: begin
                  prio = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
               end
               default: begin
                  prio = PRIO_W'($urandom);
               end
            endcase
            cmd = ($urandom_range(99) < enq_pct) ? pqxm_pkg::CMD_ENQUEUE :
                                                   pqxm_pkg::CMD_DEQUEUE;
            add_item(cmd, prio, VALUE_W'($urandom));
         end
      end
      item_total = pending_commands.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_total != item_total || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * DEPTH + 8) @(posedge clock);

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
